@@ rtl/core/ahpid_pkg.sv @@
// ----------------------------------------------------------------------------
// ahpid_pkg
// Types, constants and helpers shared by the altitude-hold position loop.
// ----------------------------------------------------------------------------
package ahpid_pkg;

  // multiplier, accumulator and configuration widths
  localparam int unsigned ACC_W  = 52;
  localparam int unsigned MPL_W  = 16;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 16;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_KP   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_KI   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KD   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WGT  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DT   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_HMAX = 3'd5;
  localparam logic [CFG_IW-1:0] REG_HMIN = 3'd6;

  // loop constants
  localparam int STICK_CENTRE = 500;
  localparam int STICK_DEADBAND = 100;
  localparam int SPEED_LIMIT = 300;
  localparam int OUT_LIMIT = 500;
  // integral limit is weight * 300 in Q8.8, moved to Q16.16
  localparam logic signed [ACC_W-1:0] INT_LIM_MULT = 52'sd76800;
  localparam logic signed [ACC_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -52'sd2147483648;
  localparam logic signed [ACC_W-1:0] OUT_MAX_Q = 52'sd32768000;

  // capture action code
  localparam logic ACT_CAPTURE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_POST,
    ST_FIN
  } state_t;

  // one product of the control step, in order
  typedef enum logic [2:0] {
    PH_SPD,
    PH_ERR,
    PH_INC1,
    PH_INC2,
    PH_LIM,
    PH_VS,
    PH_DER
  } phase_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fffffff;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/core/altitude_hold_position_pid.sv @@
// ----------------------------------------------------------------------------
// altitude_hold_position_pid
// Ultrasonic altitude-hold position loop with a bit-serial shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per control tick. in_tuser is the action (0 step,
//           1 capture target from measured height and clear history).
//   out_* : one transaction per input, speed_demand in mm/s (-500..500).
//   cfg_* : register writes, taken whenever cfg_wr_en is high; write only
//           while the block is idle.
// Sequencing:
//   a control step runs seven products through one shift-add multiplier
//   that handles one multiplier bit per cycle (a load step, one shift step
//   per multiplier bit and a post step each); the result then waits in the
//   finish state until the output slot is free, and out_tvalid rises as it
//   moves into the slot. A capture goes straight to the finish state. One
//   item is in work at a time; in_tready is high only while idle.
// Reset: synchronous, active low; registers return to their reset values and
//   target, integral and previous error are cleared.
// Stall: the result waits in the output register while out_tready is low; a
//   new item is accepted meanwhile, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module altitude_hold_position_pid (
  input  logic                            clk,
  input  logic                            rst_n,
  // fields from bit 0: throttle[9:0], measured_height[12:0],
  // vertical_speed[12:0], accel_only_mode[0]
  input  logic [39:0]                     in_tdata,
  // fields: action[0]
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fields from bit 0: speed_demand[9:0]
  output logic [15:0]                     out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_wr_en,
  input  logic [ahpid_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [ahpid_pkg::CFG_DW-1:0]    cfg_wdata
);
  import ahpid_pkg::*;

  // configuration
  logic [15:0] kp_r, ki_r, kd_r, wgt_r, dt_r;
  logic [12:0] hmax_r, hmin_r;

  // loop state
  logic signed [31:0] target_r, integ_r, prev_r;

  // item registers
  logic [12:0]        meas_r;
  logic signed [12:0] vs_r;
  logic               accel_r;
  logic signed [9:0]  speed_r;
  logic signed [31:0] err_r, tmp_r;
  logic signed [ACC_W-1:0] inc_r, sum_r;

  // serial multiplier
  logic signed [ACC_W-1:0] mcand_r, acc_r;
  logic [MPL_W-1:0]        mplier_r;
  logic [3:0]              cnt_r;

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic              out_valid_r;
  logic signed [9:0] res_r, res_nxt, pend_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 16'd128; ki_r <= 16'd0; kd_r <= 16'd640; wgt_r <= 16'd256;
      dt_r <= 16'd2458; hmax_r <= 13'd3000; hmin_r <= 13'd100;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KP:   kp_r <= cfg_wdata;
        REG_KI:   ki_r <= cfg_wdata;
        REG_KD:   kd_r <= cfg_wdata;
        REG_WGT:  wgt_r <= cfg_wdata;
        REG_DT:   dt_r <= cfg_wdata;
        REG_HMAX: hmax_r <= cfg_wdata[12:0];
        REG_HMIN: hmin_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // stick to climb speed, with the height window applied
  logic signed [10:0] dev;
  logic signed [10:0] spd;
  logic signed [9:0]  spd_lim;
  always_comb begin
    dev = $signed({1'b0, in_tdata[9:0]}) - 11'(STICK_CENTRE);
    if (dev > 11'(STICK_DEADBAND)) spd = dev - 11'(STICK_DEADBAND);
    else if (dev < -11'(STICK_DEADBAND)) spd = dev + 11'(STICK_DEADBAND);
    else spd = '0;
    if (spd > 11'(SPEED_LIMIT)) spd = 11'(SPEED_LIMIT);
    else if (spd < -11'(SPEED_LIMIT)) spd = -11'(SPEED_LIMIT);
    spd_lim = spd[9:0];
    if (target_r > $signed({3'b000, hmax_r, 16'h0000})) begin
      if (spd_lim > 10'sd0) spd_lim = '0;
    end else if (target_r < $signed({3'b000, hmin_r, 16'h0000})) begin
      if (spd_lim < 10'sd0) spd_lim = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = (in_tuser == ACT_CAPTURE) ? ST_FIN : ST_LOAD;
      ST_LOAD: state_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == 4'd15) state_nxt = ST_POST;
      ST_POST: state_nxt = (phase_r == PH_DER) ? ST_FIN : ST_LOAD;
      ST_FIN:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
  end
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, res_r};

  // rounded product views for the post step
  logic signed [ACC_W-1:0] rnd8, rnd9, rnd16, lim, isum, tot, tot_c, rnd_out;
  logic signed [31:0]      deriv, integ_new;
  always_comb begin
    rnd8  = (acc_r + 52'sd128) >>> 8;
    rnd9  = (acc_r + 52'sd256) >>> 9;
    rnd16 = (acc_r + 52'sd32768) >>> 16;
    lim   = (acc_r > SAT_MAX) ? SAT_MAX : acc_r;
    isum  = ACC_W'(integ_r) + inc_r;
    if (isum > lim) integ_new = lim[31:0];
    else if (isum < -lim) integ_new = 32'(-lim);
    else integ_new = isum[31:0];
    deriv = sat32(rnd9);
    tot   = ACC_W'(err_r) + ACC_W'(integ_r) + ACC_W'(deriv);
    if (tot > OUT_MAX_Q) tot_c = OUT_MAX_Q;
    else if (tot < -OUT_MAX_Q) tot_c = -OUT_MAX_Q;
    else tot_c = tot;
    rnd_out = (tot_c + 52'sd32768) >>> 16;
    res_nxt = accel_r ? 10'sd0 : rnd_out[9:0];
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SPD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) phase_r <= PH_SPD;
      else if (state_r == ST_POST && phase_r != PH_DER) phase_r <= phase_t'(phase_r + 3'd1);
      if (state_r == ST_LOAD) cnt_r <= '0;
      else if (state_r == ST_RUN) cnt_r <= cnt_r + 4'd1;
    end
  end

  // datapath and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      integ_r  <= '0;
      prev_r   <= '0;
    end else begin
      case (state_r)
        // latch the item, or capture at once
        ST_IDLE: begin
          if (in_acc) begin
            meas_r  <= in_tdata[22:10];
            vs_r    <= $signed(in_tdata[35:23]);
            accel_r <= in_tdata[36];
            speed_r <= spd_lim;
            if (in_tuser == ACT_CAPTURE) begin
              target_r <= {3'b000, in_tdata[22:10], 16'h0000};
              integ_r  <= '0;
              prev_r   <= '0;
              accel_r  <= 1'b1;
              pend_r   <= '0;
            end
          end
        end
        // operands for the next product
        ST_LOAD: begin
          acc_r <= '0;
          case (phase_r)
            PH_SPD:  begin mcand_r <= ACC_W'(speed_r); mplier_r <= dt_r; end
            PH_ERR:  begin
              mcand_r  <= ACC_W'(target_r) - ACC_W'($signed({3'b000, meas_r, 16'h0000}));
              mplier_r <= kp_r;
            end
            PH_INC1: begin mcand_r <= ACC_W'(err_r); mplier_r <= ki_r; end
            PH_INC2: begin mcand_r <= ACC_W'(tmp_r); mplier_r <= dt_r; end
            PH_LIM:  begin mcand_r <= INT_LIM_MULT; mplier_r <= wgt_r; end
            PH_VS:   begin mcand_r <= -ACC_W'(vs_r); mplier_r <= dt_r; end
            PH_DER:  begin mcand_r <= sum_r; mplier_r <= kd_r; end
            default: begin mcand_r <= '0; mplier_r <= '0; end
          endcase
        end
        // one multiplier bit per cycle
        ST_RUN: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= mcand_r <<< 1;
          mplier_r <= mplier_r >> 1;
        end
        // fold the product into the loop
        ST_POST: begin
          case (phase_r)
            PH_SPD:  target_r <= sat32(ACC_W'(target_r) + acc_r);
            PH_ERR:  err_r <= sat32(rnd8);
            PH_INC1: tmp_r <= sat32(rnd8);
            PH_INC2: inc_r <= rnd16;
            PH_LIM:  integ_r <= integ_new;
            PH_VS:   sum_r <= acc_r + ACC_W'(err_r) - ACC_W'(prev_r);
            PH_DER:  begin
              pend_r <= res_nxt;
              prev_r <= err_r;
            end
            default: ;
          endcase
        end
        // move the finished result into the output slot once it is free
        ST_FIN: begin
          if (!out_valid_r || out_tready) res_r <= pend_r;
        end
        default: ;
      endcase
    end
  end

  // output slot; a capture leaves a zero result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

endmodule

@@ rtl/core/ahpid_checker.sv @@
// ----------------------------------------------------------------------------
// ahpid_checker
// Port-level checks on the altitude-hold position loop.
// ----------------------------------------------------------------------------
module ahpid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // result stays inside the output clamp
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[9:0]) <= 10'sd500 &&
                    $signed(out_tdata[9:0]) >= -10'sd500 && out_tdata[15:10] == 6'd0))
    else $error("result outside clamp");

  // one item in work at a time
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // nothing offered straight after reset
  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind altitude_hold_position_pid ahpid_checker u_ahpid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

@@ tb/altitude_hold_position_pid_test.sv @@
// ----------------------------------------------------------------------------
// altitude_hold_position_pid_test
// Self-checking bench for the altitude-hold position loop: drives control
// ticks and captures, predicts each speed demand bit for bit in Q16.16 and
// compares every result transaction, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module altitude_hold_position_pid_test;
  import ahpid_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  bit failed = 0;
  bit hold_off = 0;
  bit quiet = 0;

  typedef struct {
    logic        action;
    logic [9:0]  throttle;
    logic [12:0] height;
    logic [12:0] vspeed;
    logic        accel_only;
  } tick_t;

  // scoreboard: loop predictor and queue of pending speed demands
  class demand_board;
    longint kp, ki, kd, weight, dt, hmax, hmin;
    longint target, integ, prev_err;
    logic [9:0] pending[$];

    function new();
      kp = 128; ki = 0; kd = 640; weight = 256; dt = 2458; hmax = 3000; hmin = 100;
      target = 0; integ = 0; prev_err = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [15:0] v);
      case (idx)
        REG_KP:   kp = v;
        REG_KI:   ki = v;
        REG_KD:   kd = v;
        REG_WGT:  weight = v;
        REG_DT:   dt = v;
        REG_HMAX: hmax = v[12:0];
        REG_HMIN: hmin = v[12:0];
        default: ;
      endcase
    endfunction

    // round to nearest, halves toward +inf
    function longint rnd(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_tick(tick_t t);
      longint meas_q, dev, spd, err, inc, lim, sum, der, res;
      meas_q = longint'(t.height) << 16;
      if (t.action == ACT_CAPTURE) begin
        target = meas_q; integ = 0; prev_err = 0;
        pending.push_back('0);
        return;
      end
      dev = longint'(t.throttle) - STICK_CENTRE;
      if (dev > STICK_DEADBAND) spd = dev - STICK_DEADBAND;
      else if (dev < -STICK_DEADBAND) spd = dev + STICK_DEADBAND;
      else spd = 0;
      spd = clamp(spd, -SPEED_LIMIT, SPEED_LIMIT);
      if (target > (hmax << 16)) begin
        if (spd > 0) spd = 0;
      end else if (target < (hmin << 16)) begin
        if (spd < 0) spd = 0;
      end
      target = sat(target + spd * dt);
      err = sat(rnd(kp * (target - meas_q), 8));
      inc = sat(rnd(ki * err, 8));
      inc = rnd(inc * dt, 16);
      lim = clamp(weight * 300 * 256, 0, 64'sd2147483647);
      integ = clamp(integ + inc, -lim, lim);
      sum = -longint'($signed(t.vspeed)) * dt + (err - prev_err);
      der = sat(rnd(kd * sum, 9));
      res = clamp(err + integ + der, -longint'(OUT_LIMIT) << 16, longint'(OUT_LIMIT) << 16);
      prev_err = err;
      res = rnd(res, 16);
      if (t.accel_only) res = 0;
      pending.push_back(res[9:0]);
    endfunction

    function bit check_demand(logic [15:0] got);
      logic [9:0] exp_d;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: speed_demand %0d", $signed(got[9:0]));
        return 0;
      end
      exp_d = pending.pop_front();
      if (got[9:0] !== exp_d) begin
        $error("speed_demand mismatch: expected %0d, actual %0d",
               $signed(exp_d), $signed(got[9:0]));
        return 0;
      end
      if (got[15:10] !== '0) begin
        $error("out_tdata padding mismatch: expected 0, actual %0h", got[15:10]);
        return 0;
      end
      return 1;
    endfunction
  endclass

  demand_board board = new();

  altitude_hold_position_pid dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      if (!board.check_demand(out_tdata)) failed = 1;
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (quiet) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 7);
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_reg(idx, v);
  endtask

  // wait until every pending demand has come, then let the block settle
  task automatic drain();
    int n;
    n = 0;
    while (board.pending.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (140) @(posedge clk);
  endtask

  task automatic send_tick(tick_t t);
    while (!quiet && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= t.action;
    in_tdata <= {3'b0, t.accel_only, t.vspeed, t.height, t.throttle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_tick(t);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.action = ($urandom_range(99) < 6);
    case ($urandom_range(3))
      0: t.throttle = 10'($urandom);
      1: t.throttle = 10'($urandom_range(1000));
      default: t.throttle = 10'($urandom_range(700, 300));
    endcase
    t.height = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(3500));
    t.vspeed = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($signed($urandom_range(400)) - 200);
    t.accel_only = ($urandom_range(99) < 8);
    return t;
  endfunction

  function automatic tick_t mk(logic a, int th, int h, int vs, logic ao);
    tick_t t;
    t.action = a; t.throttle = 10'(th); t.height = 13'(h); t.vspeed = 13'(vs);
    t.accel_only = ao;
    return t;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 3 + 40);
      send_tick(rand_tick());
    end
    quiet = 0;
    idle_input();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: captures, stick extremes, height window, mode, field extremes
    send_tick(mk(1, 500, 1000, 0, 0));
    send_tick(mk(0, 1000, 1000, 0, 0));
    send_tick(mk(0, 0, 1000, 0, 0));
    send_tick(mk(0, 1023, 8191, 4095, 0));
    send_tick(mk(0, 599, 0, -4096, 0));
    send_tick(mk(0, 601, 500, 100, 1));
    send_tick(mk(0, 400, 500, -100, 0));
    send_tick(mk(0, 399, 500, 0, 0));
    send_tick(mk(1, 0, 8191, 0, 1));
    send_tick(mk(0, 1000, 8191, 0, 0));
    send_tick(mk(1, 500, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 8191, -1, 0));
    idle_input();
    drain();

    // extreme gains, zero weight, step time max, min above max
    write_reg(REG_KP, 16'hffff);
    write_reg(REG_KI, 16'hffff);
    write_reg(REG_KD, 16'hffff);
    write_reg(REG_WGT, 16'h0000);
    write_reg(REG_DT, 16'hffff);
    write_reg(REG_HMAX, 16'h0000);
    write_reg(REG_HMIN, 16'h1fff);
    send_tick(mk(1, 0, 4000, 0, 0));
    send_tick(mk(0, 1000, 0, 4095, 0));
    send_tick(mk(0, 0, 8191, -4096, 0));
    send_tick(mk(0, 1023, 100, 1, 1));
    idle_input();
    drain();
    random_phase(250);

    // weight max, step time zero, unmasked upper bits on height registers
    write_reg(REG_KP, 16'd0);
    write_reg(REG_KI, 16'd4000);
    write_reg(REG_KD, 16'd0);
    write_reg(REG_WGT, 16'hffff);
    write_reg(REG_DT, 16'd0);
    write_reg(REG_HMAX, 16'hffff);
    write_reg(REG_HMIN, 16'he000);
    random_phase(200);

    // moderate loop with integral, then pressure: long receiver hold-off
    write_reg(REG_KP, 16'd300);
    write_reg(REG_KI, 16'd200);
    write_reg(REG_KD, 16'd500);
    write_reg(REG_WGT, 16'd300);
    write_reg(REG_DT, 16'd3000);
    write_reg(REG_HMAX, 16'd3000);
    write_reg(REG_HMIN, 16'd100);
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      random_phase(500);
    join

    // large step time, alternating bit patterns on ki, kd and the height registers
    write_reg(REG_KP, 16'd1);
    write_reg(REG_KI, 16'h5555);
    write_reg(REG_KD, 16'haaaa);
    write_reg(REG_WGT, 16'd1);
    write_reg(REG_DT, 16'd40000);
    write_reg(REG_HMAX, 16'h1555);
    write_reg(REG_HMIN, 16'h0aaa);
    random_phase(500);

    // back to the reset setting
    write_reg(REG_KP, 16'd128);
    write_reg(REG_KI, 16'd0);
    write_reg(REG_KD, 16'd640);
    write_reg(REG_WGT, 16'd256);
    write_reg(REG_DT, 16'd2458);
    write_reg(REG_HMAX, 16'd3000);
    write_reg(REG_HMIN, 16'd100);
    random_phase(480);

    if (board.pending.size() != 0) begin
      $error("%0d speed demands never arrived", board.pending.size());
      failed = 1;
    end
    if (!failed) $display("altitude_hold_position_pid regression: pass");
    else $display("altitude_hold_position_pid regression: fail");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("altitude_hold_position_pid regression: fail");
    $finish;
  end

endmodule
